>>> rtl/isa_string_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// isa string parser assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ISA_STRING_PARSER_UNIT_ASSERT_SVH
`define ISA_STRING_PARSER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent in the same cycle implies consequent
`define ISP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// condition must never hold
`define ISP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ISP_ASSERT_IMPLY(label, ante, cons)
`define ISP_ASSERT_NEVER(label, cond)
`endif

`endif

>>> rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isa string parser package
// shared types, register codes and candidate name tables
// ----------------------------------------------------------------------------
package isp_pkg;

    // parse phases of the back end
    typedef enum logic [2:0] {
        PH_R,
        PH_V,
        PH_D1,
        PH_D2,
        PH_LETTERS,
        PH_NAMES,
        PH_ERROR
    } phase_t;

    // digit codes found by the front end
    typedef enum logic [2:0] {
        DG_NONE,
        DG_TWO,
        DG_THREE,
        DG_FOUR,
        DG_SIX
    } digit_t;

    // one classified character as it travels through the queue
    typedef struct packed {
        logic       is_r;
        logic       is_v;
        digit_t     digit;
        logic       is_under;
        logic       is_letter;
        logic [4:0] letter_idx;
        logic [7:0] char_byte;
        logic       final_char;
    } char_item_t;

    // queue status seen by front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    // bit selections for the multi-letter names
    typedef struct packed {
        logic [5:0] smaia;
        logic [5:0] ssaia;
        logic [5:0] sstc;
    } bit_sel_t;

    // register indexes
    localparam logic [1:0] REG_SMAIA = 2'd0;
    localparam logic [1:0] REG_SSAIA = 2'd1;
    localparam logic [1:0] REG_SSTC  = 2'd2;

    localparam logic [5:0] SMAIA_RESET = 6'd26;
    localparam logic [5:0] SSAIA_RESET = 6'd27;
    localparam logic [5:0] SSTC_RESET  = 6'd28;

    localparam logic [6:0] WIDTH_32 = 7'd32;
    localparam logic [6:0] WIDTH_64 = 7'd64;

    localparam int unsigned NUM_CAND = 3;
    localparam int unsigned CAND_SMAIA = 0;
    localparam int unsigned CAND_SSAIA = 1;
    localparam int unsigned CAND_SSTC  = 2;

    // length of each candidate name
    function automatic logic [2:0] cand_len(input int unsigned k);
        logic [2:0] len;
        case (k)
            CAND_SMAIA: len = 3'd5;
            CAND_SSAIA: len = 3'd5;
            default:    len = 3'd4;
        endcase
        return len;
    endfunction

    // character of candidate k at position pos
    function automatic logic [7:0] cand_char(input int unsigned k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            CAND_SMAIA:
            begin
                case (pos)
                    3'd0:    ch = "s";
                    3'd1:    ch = "m";
                    3'd2:    ch = "a";
                    3'd3:    ch = "i";
                    3'd4:    ch = "a";
                    default: ch = 8'h00;
                endcase
            end
            CAND_SSAIA:
            begin
                case (pos)
                    3'd0:    ch = "s";
                    3'd1:    ch = "s";
                    3'd2:    ch = "a";
                    3'd3:    ch = "i";
                    3'd4:    ch = "a";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    ch = "s";
                    3'd1:    ch = "s";
                    3'd2:    ch = "t";
                    3'd3:    ch = "c";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/isa_string_parser_unit.sv
// ----------------------------------------------------------------------------
// isa_string_parser_unit
// parses a riscv isa string byte by byte into width and extension bitmap
// ----------------------------------------------------------------------------
// Usage:
//   input channel: char_byte and final_char, transfer when push && !full.
//   result channel: word_length, extension_map, parse_status, shown while
//   empty is low, transfer when pop && !empty. One result per final byte.
//   config: APB-style port, smaia/ssaia/sstc bit indexes at 0x0, 0x4, 0x8;
//   write only while no string is in flight.
// Timing:
//   one byte per cycle sustained while no final byte waits for the result
//   register. The front classifier is combinational; a byte is written into
//   the two-entry queue, the parser consumes it there and registers a final
//   byte's result for the ports; the parser's phase update sets the rate.
// Stall and reset:
//   while a result waits, non-final bytes keep flowing; a final byte waits at
//   the queue head until the result register frees, and full rises once the
//   queue holds two bytes. Reset empties the queue and result register,
//   returns the parser to expect-r and restores the bit index defaults.
// ----------------------------------------------------------------------------
`include "isa_string_parser_unit_assert.svh"

module isa_string_parser_unit
    import isp_pkg::*;
#(
    parameter int unsigned MAP_WIDTH  = 64,
    parameter int unsigned NAME_LIMIT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_byte,
    input  logic        final_char,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  word_length,
    output logic [63:0] extension_map,
    output logic        parse_status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    queue_status_t q_status;
    char_item_t    wr_item;
    char_item_t    rd_item;
    logic          q_write;
    logic          q_read;
    bit_sel_t      bit_sel_reg, bit_sel_next;
    logic          cfg_write;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        bit_sel_next = bit_sel_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SMAIA: bit_sel_next.smaia = pwdata[5:0];
                REG_SSAIA: bit_sel_next.ssaia = pwdata[5:0];
                REG_SSTC:  bit_sel_next.sstc  = pwdata[5:0];
                default:   bit_sel_next = bit_sel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_sel_reg.smaia <= SMAIA_RESET;
            bit_sel_reg.ssaia <= SSAIA_RESET;
            bit_sel_reg.sstc  <= SSTC_RESET;
        end
        else
        begin
            bit_sel_reg <= bit_sel_next;
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SMAIA: prdata = {26'd0, bit_sel_reg.smaia};
            REG_SSAIA: prdata = {26'd0, bit_sel_reg.ssaia};
            REG_SSTC:  prdata = {26'd0, bit_sel_reg.sstc};
            default:   prdata = 32'd0;
        endcase
    end

    // front end
    isp_classify u_classify (
        .push       (push),
        .char_byte  (char_byte),
        .final_char (final_char),
        .q_status   (q_status),
        .q_write    (q_write),
        .q_item     (wr_item)
    );

    // decoupling queue
    isp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_write),
        .wr_item (wr_item),
        .rd_en   (q_read),
        .rd_item (rd_item),
        .status  (q_status)
    );

    // back end
    isp_parser #(
        .MAP_WIDTH  (MAP_WIDTH),
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_item        (rd_item),
        .q_read        (q_read),
        .bit_sel       (bit_sel_reg),
        .pop           (pop),
        .empty         (empty),
        .word_length   (word_length),
        .extension_map (extension_map),
        .parse_status  (parse_status)
    );

    assign full = q_status.full;

    // error results carry no width and no bitmap
    `ISP_ASSERT_IMPLY(a_error_clean, !empty && parse_status, (word_length == 7'd0) && (extension_map == 64'd0))
    // valid results carry a real width
    `ISP_ASSERT_IMPLY(a_valid_width, !empty && !parse_status, (word_length == 7'd32) || (word_length == 7'd64))
    // the parser never drains an empty queue
    `ISP_ASSERT_NEVER(a_read_empty, q_read && !q_status.not_empty)

endmodule

>>> rtl/isp_classify.sv
// ----------------------------------------------------------------------------
// isp_classify
// front end: takes bytes in and tags prefix, digit, underscore and letter codes
// ----------------------------------------------------------------------------
module isp_classify
    import isp_pkg::*;
(
    input  logic          push,
    input  logic [7:0]    char_byte,
    input  logic          final_char,
    input  queue_status_t q_status,
    output logic          q_write,
    output char_item_t    q_item
);

    // transfer into the queue when a byte is pushed and there is room
    assign q_write = push && !q_status.full;

    // byte classification
    always_comb
    begin
        q_item            = '0;
        q_item.char_byte  = char_byte;
        q_item.final_char = final_char;
        q_item.is_r       = (char_byte == "r") || (char_byte == "R");
        q_item.is_v       = (char_byte == "v") || (char_byte == "V");
        q_item.is_under   = (char_byte == "_");
        unique case (char_byte)
            "2":     q_item.digit = DG_TWO;
            "3":     q_item.digit = DG_THREE;
            "4":     q_item.digit = DG_FOUR;
            "6":     q_item.digit = DG_SIX;
            default: q_item.digit = DG_NONE;
        endcase
        if ((char_byte >= "a") && (char_byte <= "z"))
        begin
            q_item.is_letter  = 1'b1;
            q_item.letter_idx = 5'(char_byte - 8'("a"));
        end
        else if ((char_byte >= "A") && (char_byte <= "Z"))
        begin
            q_item.is_letter  = 1'b1;
            q_item.letter_idx = 5'(char_byte - 8'("A"));
        end
    end

endmodule

>>> rtl/isp_queue.sv
// ----------------------------------------------------------------------------
// isp_queue
// two-entry queue of classified characters between front and back
// ----------------------------------------------------------------------------
module isp_queue
    import isp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  char_item_t    wr_item,
    input  logic          rd_en,
    output char_item_t    rd_item,
    output queue_status_t status
);

    char_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item          = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != 2'd0);
    assign status.full      = (count_reg == 2'd2);

endmodule

>>> rtl/isp_parser.sv
// ----------------------------------------------------------------------------
// isp_parser
// back end: runs the parse phases per character and holds the result register
// ----------------------------------------------------------------------------
module isp_parser
    import isp_pkg::*;
#(
    parameter int unsigned MAP_WIDTH  = 64,
    parameter int unsigned NAME_LIMIT = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  char_item_t    q_item,
    output logic          q_read,
    input  bit_sel_t      bit_sel,
    input  logic          pop,
    output logic          empty,
    output logic [6:0]    word_length,
    output logic [63:0]   extension_map,
    output logic          parse_status
);

    localparam int unsigned NLW = $clog2(NAME_LIMIT);

    phase_t                 phase_reg, phase_next, phase_step;
    logic                   six_reg, six_next;
    logic [MAP_WIDTH-1:0]   map_reg, map_next, set_mask;
    logic [NLW-1:0]         len_reg, len_next, len_step, fin_len;
    logic [NUM_CAND-1:0]    flags_reg, flags_next, flags_step, fin_flags, name_hit;
    logic [6:0]             width_reg, width_next;
    logic                   letter_set;
    logic                   fin;
    logic                   res_load;
    logic                   ok_next;
    logic                   res_valid_reg, res_valid_next;
    logic [6:0]             res_len_reg;
    logic [63:0]            res_map_reg;
    logic                   res_status_reg;

    // take the head item unless a final item would overrun the result register
    assign q_read   = q_status.not_empty &&
                      (!q_item.final_char || !res_valid_reg || pop);
    assign res_load = q_read && q_item.final_char;

    // next phase from the current phase and the character class
    always_comb
    begin
        phase_step = phase_reg;
        unique case (phase_reg)
            PH_R:       phase_step = q_item.is_r ? PH_V : PH_ERROR;
            PH_V:       phase_step = q_item.is_v ? PH_D1 : PH_ERROR;
            PH_D1:      phase_step = ((q_item.digit == DG_THREE) ||
                                      (q_item.digit == DG_SIX)) ? PH_D2 : PH_ERROR;
            PH_D2:      phase_step = (six_reg ? (q_item.digit == DG_FOUR)
                                              : (q_item.digit == DG_TWO))
                                     ? PH_LETTERS : PH_ERROR;
            PH_LETTERS: phase_step = q_item.is_under ? PH_NAMES : PH_LETTERS;
            PH_NAMES:   phase_step = PH_NAMES;
            default:    phase_step = PH_ERROR;
        endcase
    end

    // name matching on one more character
    always_comb
    begin
        len_step   = len_reg;
        flags_step = flags_reg;
        if (len_reg < NLW'(NAME_LIMIT - 1))
        begin
            for (int unsigned k = 0; k < NUM_CAND; k++)
            begin
                if ((len_reg >= NLW'(cand_len(k))) ||
                    (cand_char(k, len_reg[2:0]) != q_item.char_byte))
                begin
                    flags_step[k] = 1'b0;
                end
            end
            len_step = len_reg + NLW'(1);
        end
    end

    // per-item state update
    always_comb
    begin
        six_next   = six_reg;
        width_next = width_reg;
        len_next   = len_reg;
        flags_next = flags_reg;
        letter_set = 1'b0;
        fin        = 1'b0;
        fin_len    = len_reg;
        fin_flags  = flags_reg;
        unique case (phase_reg)
            PH_D1:
            begin
                six_next = (q_item.digit == DG_SIX);
            end
            PH_D2:
            begin
                width_next = six_reg ? WIDTH_64 : WIDTH_32;
            end
            PH_LETTERS:
            begin
                if (q_item.is_under)
                begin
                    len_next   = '0;
                    flags_next = '1;
                end
                else
                begin
                    letter_set = q_item.is_letter;
                end
            end
            PH_NAMES:
            begin
                if (q_item.is_under)
                begin
                    fin        = 1'b1;
                    len_next   = '0;
                    flags_next = '1;
                end
                else
                begin
                    len_next   = len_step;
                    flags_next = flags_step;
                    fin        = q_item.final_char;
                    fin_len    = len_step;
                    fin_flags  = flags_step;
                end
            end
            default:
            begin
            end
        endcase
    end

    // bitmap bits set by a letter or a finished name
    always_comb
    begin
        for (int unsigned k = 0; k < NUM_CAND; k++)
        begin
            name_hit[k] = fin && fin_flags[k] && (fin_len == NLW'(cand_len(k)));
        end
        for (int unsigned i = 0; i < MAP_WIDTH; i++)
        begin
            set_mask[i] = (letter_set && ({1'b0, q_item.letter_idx} == 6'(i))) ||
                          (name_hit[CAND_SMAIA] && (bit_sel.smaia == 6'(i))) ||
                          (name_hit[CAND_SSAIA] && (bit_sel.ssaia == 6'(i))) ||
                          (name_hit[CAND_SSTC]  && (bit_sel.sstc  == 6'(i)));
        end
        map_next   = map_reg | set_mask;
        phase_next = phase_step;
        ok_next    = (phase_step == PH_LETTERS) || (phase_step == PH_NAMES);
    end

    // parse state registers, cleared after each final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_R;
            six_reg   <= 1'b0;
            map_reg   <= '0;
            len_reg   <= '0;
            flags_reg <= '1;
            width_reg <= '0;
        end
        else if (q_read)
        begin
            if (q_item.final_char)
            begin
                phase_reg <= PH_R;
                six_reg   <= 1'b0;
                map_reg   <= '0;
                len_reg   <= '0;
                flags_reg <= '1;
                width_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                six_reg   <= six_next;
                map_reg   <= map_next;
                len_reg   <= len_next;
                flags_reg <= flags_next;
                width_reg <= width_next;
            end
        end
    end

    // result register valid flag
    assign res_valid_next = res_load || (res_valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_len_reg    <= ok_next ? width_next : 7'd0;
            res_map_reg    <= ok_next ? 64'(map_next) : 64'd0;
            res_status_reg <= !ok_next;
        end
    end

    assign empty         = !res_valid_reg;
    assign word_length   = res_len_reg;
    assign extension_map = res_map_reg;
    assign parse_status  = res_status_reg;

endmodule

>>> test/isa_string_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// isa string parser unit testbench
// streams directed and random isa strings through the byte queue, predicts
// width, extension bitmap and status per string, and checks every result
// transfer in order; bit index registers are rewritten between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module isa_string_parser_unit_tb;
    import isp_pkg::*;

    localparam int MAP_WIDTH   = 64;
    localparam int NAME_LIMIT  = 32;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    // candidate names, right-justified, entry k matches CAND_* order
    localparam logic [2:0][39:0] EXT_TEXT = {8'h00, "sstc", "ssaia", "smaia"};
    localparam logic [2:0][2:0]  EXT_LEN  = {3'd4, 3'd5, 3'd5};

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_xfer_t;

    typedef struct packed {
        logic [6:0]  wlen;
        logic [63:0] emap;
        logic        stat;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  char_byte = 8'h00;
    logic        final_char = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [6:0]  word_length;
    logic [63:0] extension_map;
    logic        parse_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    isa_string_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_byte     (char_byte),
        .final_char    (final_char),
        .empty         (empty),
        .pop           (pop),
        .word_length   (word_length),
        .extension_map (extension_map),
        .parse_status  (parse_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // stimulus and expectation stores
    char_xfer_t    char_q [$];
    logic [7:0]    text_buf [$];
    parse_result_t result_q [$];
    int            bytes_queued = 0;
    int            mismatch_cnt = 0;
    int            cycle_cnt = 0;
    logic          byte_taken = 1'b0;
    logic          steady = 1'b0;
    int            push_gap = 0;
    int            pop_hold = 0;

    // predictor copy of registers and parse state
    logic [2:0][5:0] ext_bit;
    phase_t          scan_phase;
    logic            six_first;
    logic [63:0]     map_acc;
    int              name_len;
    logic [2:0]      name_hits;
    logic [6:0]      width_acc;

    parse_result_t seen;
    parse_result_t want;
    parse_result_t fresh;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_val, $time);
        mismatch_cnt++;
    endtask

    function automatic void restart_scan();
        scan_phase = PH_R;
        six_first  = 1'b0;
        map_acc    = 64'h0;
        name_len   = 0;
        name_hits  = 3'b111;
        width_acc  = 7'd0;
    endfunction

    function automatic void mark_bit(input logic [5:0] b);
        if (b < MAP_WIDTH)
            map_acc[b] = 1'b1;
    endfunction

    // a name ends: set the bit of each candidate still matching at full length
    function automatic void close_name();
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (name_hits[k] && name_len == EXT_LEN[k])
                mark_bit(ext_bit[k]);
        end
        name_len  = 0;
        name_hits = 3'b111;
    endfunction

    // advance the parse by one byte; returns 1 when a result is due
    function automatic bit scan_byte(input logic [7:0] c, input logic is_last,
                                     output parse_result_t res);
        res = '0;
        case (scan_phase)
            PH_R:
            begin
                if (c == "r" || c == "R")
                    scan_phase = PH_V;
                else
                    scan_phase = PH_ERROR;
            end
            PH_V:
            begin
                if (c == "v" || c == "V")
                    scan_phase = PH_D1;
                else
                    scan_phase = PH_ERROR;
            end
            PH_D1:
            begin
                if (c == "3")
                begin
                    six_first  = 1'b0;
                    scan_phase = PH_D2;
                end
                else if (c == "6")
                begin
                    six_first  = 1'b1;
                    scan_phase = PH_D2;
                end
                else
                    scan_phase = PH_ERROR;
            end
            PH_D2:
            begin
                if (six_first ? (c == "4") : (c == "2"))
                begin
                    width_acc  = six_first ? WIDTH_64 : WIDTH_32;
                    scan_phase = PH_LETTERS;
                end
                else
                    scan_phase = PH_ERROR;
            end
            PH_LETTERS:
            begin
                if (c == "_")
                begin
                    name_len   = 0;
                    name_hits  = 3'b111;
                    scan_phase = PH_NAMES;
                end
                else if (c >= "a" && c <= "z")
                    mark_bit(6'(c - "a"));
                else if (c >= "A" && c <= "Z")
                    mark_bit(6'(c - "A"));
            end
            PH_NAMES:
            begin
                if (c == "_")
                    close_name();
                else if (name_len < NAME_LIMIT - 1)
                begin
                    // characters past the limit are dropped
                    for (int k = 0; k < NUM_CAND; k++)
                    begin
                        if (name_len >= EXT_LEN[k])
                            name_hits[k] = 1'b0;
                        else if (EXT_TEXT[k][8 * (EXT_LEN[k] - 1 - name_len) +: 8] != c)
                            name_hits[k] = 1'b0;
                    end
                    name_len++;
                end
            end
            default:
                scan_phase = PH_ERROR;
        endcase

        if (!is_last)
            return 1'b0;

        if (scan_phase == PH_NAMES)
            close_name();
        if (scan_phase == PH_LETTERS || scan_phase == PH_NAMES)
        begin
            res.wlen = width_acc;
            res.emap = map_acc;
            res.stat = 1'b0;
        end
        else
        begin
            res.wlen = 7'd0;
            res.emap = 64'h0;
            res.stat = 1'b1;
        end
        restart_scan();
        return 1'b1;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // driver: input side and pop, changed on the falling edge
    always @(negedge clk)
    begin
        if (byte_taken)
        begin
            void'(char_q.pop_front());
            push_gap = idle_len();
        end
        if (push && !byte_taken)
            ;
        else if (push_gap > 0)
        begin
            push_gap--;
            push <= 1'b0;
        end
        else if (char_q.size() > 0)
        begin
            push       <= 1'b1;
            char_byte  <= char_q[0].ch;
            final_char <= char_q[0].fin;
        end
        else
            push <= 1'b0;

        if (pop_hold > 0)
        begin
            pop_hold--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold = idle_len();
        end
    end

    // monitor: predict on each byte transfer, check each result transfer
    always @(posedge clk)
    begin
        byte_taken <= rst_n && push && !full;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (scan_byte(char_byte, final_char, fresh))
                    result_q.push_back(fresh);
            end
            if (pop && !empty)
            begin
                seen.wlen = word_length;
                seen.emap = extension_map;
                seen.stat = parse_status;
                if (result_q.size() == 0)
                    note_mismatch("result with none pending", seen.emap, 64'h0);
                else
                begin
                    want = result_q.pop_front();
                    if (seen.wlen !== want.wlen)
                        note_mismatch("word_length", seen.wlen, want.wlen);
                    if (seen.emap !== want.emap)
                        note_mismatch("extension_map", seen.emap, want.emap);
                    if (seen.stat !== want.stat)
                        note_mismatch("parse_status", seen.stat, want.stat);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_check(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'h0, rd);
        if (rd !== {26'd0, ext_bit[idx]})
            note_mismatch("bit index readback", rd, {26'd0, ext_bit[idx]});
    endtask

    // write a bit index register; for a used index, track it and read it back
    task automatic set_bit_index(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        if (idx != REG_UNUSED)
        begin
            ext_bit[idx] = value[5:0];
            read_check(idx);
        end
    endtask

    function automatic logic [31:0] pick_index(input int ph);
        logic [31:0] v;
        v = $urandom();
        case (ph)
            1:       v[5:0] = 6'd0;
            2:       v[5:0] = 6'd63;
            3:       v[5:0] = 6'd5;
            default: ;
        endcase
        return v;
    endfunction

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // move the built string into the send queue, flag on the last byte
    task automatic flush_text();
        char_xfer_t x;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            x.ch  = text_buf[i];
            x.fin = (i == text_buf.size() - 1);
            char_q.push_back(x);
        end
        bytes_queued += text_buf.size();
        text_buf.delete();
    endtask

    task automatic build_string();
        logic [7:0] pre [4];
        int n;
        int k;
        pre[0] = $urandom_range(0, 1) ? "r" : "R";
        pre[1] = $urandom_range(0, 1) ? "v" : "V";
        if ($urandom_range(0, 1))
        begin
            pre[2] = "3";
            pre[3] = "2";
        end
        else
        begin
            pre[2] = "6";
            pre[3] = "4";
        end

        if ($urandom_range(0, 99) < 15)
        begin
            // broken prefix: cut short, spoiled byte or crossed digits
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++)
                text_buf.push_back(pre[i]);
            if (k == 0 || $urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 1))
                    text_buf.push_back(8'($urandom_range(0, 255)));
                else
                    text_buf.push_back(8'h32 + 8'($urandom_range(0, 4)));
            end
            n = $urandom_range(0, 4);
            repeat (n)
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                text_buf.push_back(pre[i]);
            // single-letter extensions, some noise
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 4) != 0)
                    text_buf.push_back(($urandom_range(0, 1) ? "a" : "A")
                                       + 8'($urandom_range(0, 25)));
                else
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            // multi-letter names
            if ($urandom_range(0, 3) != 0)
            begin
                text_buf.push_back("_");
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        text_buf.push_back("_");
                    case ($urandom_range(0, 11))
                        0, 1: put_str("smaia");
                        2, 3: put_str("ssaia");
                        4, 5: put_str("sstc");
                        6:
                        begin
                            case ($urandom_range(0, 2))
                                0:       put_str("SSTC");
                                1:       put_str("Smaia");
                                default: put_str("ssAia");
                            endcase
                        end
                        7:
                        begin
                            case ($urandom_range(0, 3))
                                0:       put_str("smai");
                                1:       put_str("ssaiaa");
                                2:       put_str("sst");
                                default: put_str("sstcs");
                            endcase
                        end
                        8: ;
                        9:
                        begin
                            // long name around the truncation limit
                            k = $urandom_range(28, 40);
                            put_str("sstc");
                            repeat (k - 4)
                                text_buf.push_back("a" + 8'($urandom_range(0, 25)));
                        end
                        default:
                        begin
                            k = $urandom_range(1, 6);
                            repeat (k)
                                text_buf.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    text_buf.push_back("_");
            end
        end
        if (text_buf.size() == 0)
            text_buf.push_back(8'($urandom_range(0, 255)));
        flush_text();
    endtask

    task automatic feed_random(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target)
            build_string();
    endtask

    // wait until every byte is sent and every result taken, then settle
    task automatic drain();
        while (char_q.size() != 0 || result_q.size() != 0)
            @(negedge clk);
        repeat (6)
            @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        ext_bit[CAND_SMAIA] = SMAIA_RESET;
        ext_bit[CAND_SSAIA] = SSAIA_RESET;
        ext_bit[CAND_SSTC]  = SSTC_RESET;
        restart_scan();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of the bit index registers
        read_check(REG_SMAIA);
        read_check(REG_SSAIA);
        read_check(REG_SSTC);

        // directed: early end, bad digit, both letter cases, byte extremes,
        // empty name between two known names
        put_str("R");
        flush_text();
        put_str("rv34");
        flush_text();
        put_str("RV64aZ");
        text_buf.push_back(8'h01);
        text_buf.push_back(8'hFF);
        put_str("_smaia__sstc");
        flush_text();

        feed_random(100);
        drain();

        // phases with new bit index settings
        for (int ph = 1; ph <= 7; ph++)
        begin
            steady = (ph == 3);
            if (ph == 4)
                set_bit_index(REG_UNUSED, $urandom());
            set_bit_index(REG_SMAIA, pick_index(ph));
            set_bit_index(REG_SSAIA, pick_index(ph));
            set_bit_index(REG_SSTC, pick_index(ph));
            feed_random(100);
            drain();
        end

        while (result_q.size() != 0)
        begin
            note_mismatch("result never arrived", result_q[0].emap, 64'h0);
            void'(result_q.pop_front());
        end

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
